FILE: src/esvt_pkg.sv
// Shared types and constants of the encoder synced camera and valve timer.
`timescale 1ns / 1ps
package esvt_pkg;

  // Frame geometry and row queue size.
  localparam int ROWS_PER_FRAME = 4;
  localparam int QUEUE_DEPTH    = 1024;

  // Field widths.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ACT_W     = 2;
  localparam int PAT_W     = 64;
  localparam int VCNT_W    = 17;
  localparam int RCNT_W    = 17;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);

  // Delay division: dividend is camera_to_valve_pulses * ROWS_PER_FRAME.
  localparam int DVD_W     = CFG_W + $clog2(ROWS_PER_FRAME) + 1;
  localparam int DCNT_W    = $clog2(DVD_W + 1);

  // Result packing on the output stream.
  localparam int RES_W     = PAT_W + 4;
  localparam int OUT_W     = ((RES_W + 7) / 8) * 8;

  // Front queue between classification and execution.
  localparam int FQ_DEPTH  = 2;
  localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

  // Register reset values.
  localparam logic [CFG_W-1:0] CAMERA_PULSES_RST = 16'd500;
  localparam logic [CFG_W-1:0] VALVE_PULSES_RST  = 16'd10;
  localparam logic [CFG_W-1:0] CAM_TO_VALVE_RST  = 16'd3015;

  // Counter reload values.
  localparam logic [VCNT_W-1:0] VALVE_CNT_RST = 17'd1;
  localparam logic [RCNT_W-1:0] ROW_CNT_RST   = 17'd2;

  typedef enum logic [ACT_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_PUSH  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAMERA_PULSES = 2'd0,
    CFG_VALVE_PULSES  = 2'd1,
    CFG_CAM_TO_VALVE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e              op;
    logic [PAT_W-1:0] pattern;
  } item_t;

  // First member sits in the top bits, so valve_fire lands in bit 0.
  typedef struct packed {
    logic             push_dropped;
    logic             running;
    logic             camera_fire;
    logic [PAT_W-1:0] valve_pattern;
    logic             valve_fire;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     wdata;
  } cfg_wr_t;

endpackage

FILE: src/encoder_synced_camera_valve_timer_core.sv
// Top level of the encoder synced camera trigger and valve row timer.
`timescale 1ns / 1ps
// Usage:
// Each transfer on the s_axis channel is one action: tuser carries the action
// code (encoder tick, start, stop, push row) and tdata the 64-bit row pattern,
// which only a push uses. Every action yields exactly one transfer on m_axis
// with the valve fire flag, the held valve pattern, the camera fire flag, the
// run mode after the action and the push dropped flag.
// The registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle; writes in running mode and to unused indexes are ignored.
// An action passes through a two-entry input queue and the action register of
// the execution unit before it is carried out, and its result is registered
// in the output register. The execution unit takes a new action only once it
// has finished the last one. A start out of sleep mode adds the serial delay
// division, one quotient bit per cycle. When the receiver stalls, the result
// stays in the output register and the execution unit waits; the input queue
// still takes up to two more actions before tready drops. Reset returns the
// block to sleep mode with the register reset values and an empty row queue;
// the row memory is not cleared and needs no clearing pass.
module encoder_synced_camera_valve_timer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream: tdata = row_pattern[63:0]; tuser = action[1:0].
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [esvt_pkg::PAT_W-1:0]     s_axis_tdata,
  input  logic [esvt_pkg::ACT_W-1:0]     s_axis_tuser,
  // Output stream: tdata = valve_fire[0], valve_pattern[64:1], camera_fire[65],
  // running[66], push_dropped[67], zero fill[71:68].
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [esvt_pkg::OUT_W-1:0]     m_axis_tdata,
  // Register write port.
  input  logic                           cfg_we_i,
  input  logic [esvt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [esvt_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import esvt_pkg::*;

  logic    item_valid, item_ready;
  item_t   item;
  cfg_wr_t cfg_wr;
  result_t res;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.idx   = cfg_idx_i;
  assign cfg_wr.wdata = cfg_wdata_i;

  esvt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  esvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {{(OUT_W - RES_W){1'b0}}, res};

endmodule

FILE: src/esvt_front.sv
// Input side: accepts stream transfers, decodes the action and queues the items.
`timescale 1ns / 1ps
module esvt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [esvt_pkg::PAT_W-1:0] s_axis_tdata,
  input  logic [esvt_pkg::ACT_W-1:0] s_axis_tuser,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output esvt_pkg::item_t            item_o
);
  import esvt_pkg::*;

  item_t                fq_mem_q [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FQ_CNT_W-1:0]  cnt_q, cnt_d;
  item_t                item_in;
  logic                 push, pop;

  // Decode the action; only a push carries a meaningful row pattern.
  always_comb begin
    item_in.op      = op_e'(s_axis_tuser);
    item_in.pattern = (item_in.op == OP_PUSH) ? s_axis_tdata : '0;
  end

  assign s_axis_tready = (cnt_q != FQ_CNT_W'(FQ_DEPTH));
  assign item_valid_o  = (cnt_q != '0);
  assign item_o        = fq_mem_q[rd_ptr_q];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = item_valid_o && item_ready_i;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue entries hold payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

FILE: src/esvt_div.sv
// Restoring divider, one quotient bit per cycle, for the travel delay in rows.
`timescale 1ns / 1ps
module esvt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [esvt_pkg::DVD_W-1:0] dividend_i,
  input  logic [esvt_pkg::CFG_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [esvt_pkg::DVD_W-1:0] quot_o
);
  import esvt_pkg::*;

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [CFG_W-1:0]  dvs_q, dvs_d;
  logic [CFG_W:0]    rem_sh;
  logic              take;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    take   = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = take ? CFG_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CFG_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

FILE: src/esvt_back.sv
// Execution side: registers, counters, row queue memory and the result register.
`timescale 1ns / 1ps
module esvt_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  esvt_pkg::cfg_wr_t      cfg_i,
  input  logic                   item_valid_i,
  output logic                   item_ready_o,
  input  esvt_pkg::item_t        item_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output esvt_pkg::result_t      res_o
);
  import esvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [PAT_W-1:0]   pat_q, pat_d;

  logic [CFG_W-1:0]   cam_pulses_q, cam_pulses_d;
  logic [CFG_W-1:0]   valve_pulses_q, valve_pulses_d;
  logic [CFG_W-1:0]   cam_to_valve_q, cam_to_valve_d;

  logic               run_q, run_d;
  logic [VCNT_W-1:0]  valve_cnt_q, valve_cnt_d;
  logic [RCNT_W-1:0]  row_cnt_q, row_cnt_d;
  logic [CFG_W-1:0]   cam_cnt_q, cam_cnt_d;
  logic [CFG_W-1:0]   row_int_q, row_int_d;
  logic [PAT_W-1:0]   held_q, held_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  pend_q, pend_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;

  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  logic [PAT_W-1:0]   row_mem [QUEUE_DEPTH];
  logic [PAT_W-1:0]   rd_data_q;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;

  logic               div_start, div_busy;
  logic [DVD_W-1:0]   div_dividend, div_quot;

  logic [CFG_W-1:0]   cp_eff, vp_eff, row_int_calc;
  logic [VCNT_W-1:0]  vc_inc;
  logic [RCNT_W-1:0]  rc_inc;
  logic [CFG_W-1:0]   cc_inc;
  logic               vfire, rload, cfire;
  logic [FILL_W:0]    occupancy;
  logic               q_full, slot_free;
  logic [FILL_W-1:0]  delay_rows;
  result_t            res;

  // Travel delay divider, started when a start leaves sleep mode.
  esvt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cp_eff),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // Values shared by several actions.
  always_comb begin
    cp_eff       = (cam_pulses_q == '0) ? CFG_W'(1) : cam_pulses_q;
    vp_eff       = (valve_pulses_q == '0) ? CFG_W'(1) : valve_pulses_q;
    row_int_calc = CFG_W'(cam_pulses_q / ROWS_PER_FRAME);
    if (row_int_calc == '0) begin
      row_int_calc = CFG_W'(1);
    end
    div_dividend = DVD_W'(cam_to_valve_q) * DVD_W'(ROWS_PER_FRAME);
    delay_rows   = (div_quot > DVD_W'(QUEUE_DEPTH)) ? FILL_W'(QUEUE_DEPTH)
                                                     : FILL_W'(div_quot);
    vc_inc       = valve_cnt_q + VCNT_W'(1);
    vfire        = (vc_inc >= ({1'b0, vp_eff} + VCNT_W'(1)));
    rc_inc       = row_cnt_q + RCNT_W'(1);
    rload        = (rc_inc >= ({1'b0, row_int_q} + RCNT_W'(2)));
    cc_inc       = cam_cnt_q + CFG_W'(1);
    cfire        = (cc_inc >= cp_eff);
    occupancy    = {1'b0, pend_q} + {1'b0, fill_q};
    q_full       = (occupancy >= (FILL_W + 1)'(QUEUE_DEPTH));
    mem_waddr    = rd_ptr_q + fill_q[PTR_W-1:0];
    slot_free    = !out_valid_q || res_ready_i;
  end

  // Sequencer: take an item, then carry it out once the result slot is free.
  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    pat_d          = pat_q;
    cam_pulses_d   = cam_pulses_q;
    valve_pulses_d = valve_pulses_q;
    cam_to_valve_d = cam_to_valve_q;
    run_d          = run_q;
    valve_cnt_d    = valve_cnt_q;
    row_cnt_d      = row_cnt_q;
    cam_cnt_d      = cam_cnt_q;
    row_int_d      = row_int_q;
    held_d         = held_q;
    fill_d         = fill_q;
    pend_d         = pend_q;
    rd_ptr_d       = rd_ptr_q;
    out_valid_d    = out_valid_q && !res_ready_i;
    out_d          = out_q;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    item_ready_o   = (state_q == S_IDLE);

    res               = '0;
    res.valve_pattern = held_q;
    res.running       = run_q;

    // Register writes are taken only in sleep mode.
    if (cfg_i.we && !run_q) begin
      case (cfg_i.idx)
        CFG_CAMERA_PULSES: cam_pulses_d   = cfg_i.wdata;
        CFG_VALVE_PULSES:  valve_pulses_d = cfg_i.wdata;
        CFG_CAM_TO_VALVE:  cam_to_valve_d = cfg_i.wdata;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          op_d    = item_i.op;
          pat_d   = item_i.pattern;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_q == OP_START && !run_q) begin
          // Empty the queue and work out the delay rows over the next cycles.
          fill_d    = '0;
          pend_d    = '0;
          rd_ptr_d  = '0;
          row_int_d = row_int_calc;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (slot_free) begin
          state_d = S_IDLE;
          unique case (op_q)
            OP_TICK: begin
              if (run_q) begin
                valve_cnt_d = vfire ? VALVE_CNT_RST : vc_inc;
                res.valve_fire = vfire;
                cam_cnt_d = cfire ? '0 : cc_inc;
                res.camera_fire = cfire;
                row_cnt_d = rload ? ROW_CNT_RST : rc_inc;
                if (rload) begin
                  if (pend_q != '0) begin
                    pend_d = pend_q - 1'b1;
                    held_d = '0;
                  end else if (fill_q != '0) begin
                    held_d   = rd_data_q;
                    rd_ptr_d = rd_ptr_q + 1'b1;
                    fill_d   = fill_q - 1'b1;
                  end else begin
                    held_d = '0;
                  end
                end
              end
            end
            OP_START: ;
            OP_STOP: begin
              if (run_q) begin
                fill_d      = '0;
                pend_d      = '0;
                rd_ptr_d    = '0;
                valve_cnt_d = VALVE_CNT_RST;
                row_cnt_d   = ROW_CNT_RST;
                cam_cnt_d   = '0;
                run_d       = 1'b0;
                res.running = 1'b0;
              end
            end
            OP_PUSH: begin
              if (q_full) begin
                res.push_dropped = 1'b1;
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + 1'b1;
              end
            end
            default: ;
          endcase
          out_valid_d = 1'b1;
          out_d       = res;
        end
      end

      S_DIV: begin
        if (!div_busy && slot_free) begin
          pend_d      = delay_rows;
          run_d       = 1'b1;
          res.running = 1'b1;
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= OP_TICK;
      cam_pulses_q   <= CAMERA_PULSES_RST;
      valve_pulses_q <= VALVE_PULSES_RST;
      cam_to_valve_q <= CAM_TO_VALVE_RST;
      run_q          <= 1'b0;
      valve_cnt_q    <= VALVE_CNT_RST;
      row_cnt_q      <= ROW_CNT_RST;
      cam_cnt_q      <= '0;
      row_int_q      <= CFG_W'(1);
      held_q         <= '0;
      fill_q         <= '0;
      pend_q         <= '0;
      rd_ptr_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      op_q           <= op_d;
      cam_pulses_q   <= cam_pulses_d;
      valve_pulses_q <= valve_pulses_d;
      cam_to_valve_q <= cam_to_valve_d;
      run_q          <= run_d;
      valve_cnt_q    <= valve_cnt_d;
      row_cnt_q      <= row_cnt_d;
      cam_cnt_q      <= cam_cnt_d;
      row_int_q      <= row_int_d;
      held_q         <= held_d;
      fill_q         <= fill_d;
      pend_q         <= pend_d;
      rd_ptr_q       <= rd_ptr_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    out_q <= out_d;
  end

  // Row queue memory; the head entry is read every cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= pat_q;
    end
    rd_data_q <= row_mem[rd_ptr_q];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Zero rows and stored rows together never exceed the queue size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= (FILL_W + 1)'(QUEUE_DEPTH))
    else $error("row queue over capacity");

  // A row is written only while the queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !q_full)
    else $error("row written into a full queue");

  // The delay division only runs for a start out of sleep mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (!run_q && op_q == OP_START))
    else $error("divider wait outside a start");

  // The row interval is never zero once running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (row_int_q != '0))
    else $error("zero row interval while running");

  // A fresh start leaves the counters at their reload values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(run_q) |-> (valve_cnt_q == VALVE_CNT_RST && row_cnt_q == ROW_CNT_RST
                      && cam_cnt_q == '0))
    else $error("counters not reloaded at start");

endmodule
